@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the grid bucket RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, off while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true.
`define ASSERT_NEVER(lbl, expr, msg) \
  `ASSERT_CLK(lbl, !(expr), msg)

`endif

@@ rtl/core/gbnp_pkg.sv @@
// Package: types, codes and constants of the grid bucket nearest point block.
`timescale 1ns / 1ps
package gbnp_pkg;

  localparam int COORD_BITS = 20;
  localparam int IDENT_BITS = 16;
  localparam int GDIM_W     = 13;
  localparam int PROD_W     = 2 * GDIM_W + 1;
  localparam int XW         = (COORD_BITS > GDIM_W) ? COORD_BITS : GDIM_W;
  localparam int CFG_W      = XW;
  localparam int CFG_IDX_W  = 3;
  localparam int SQ_W       = 2 * COORD_BITS;
  localparam int DIST_W     = SQ_W + 1;
  localparam int DIV_CNT_W  = $clog2(COORD_BITS + 1);
  localparam int NB_W       = 4;
  localparam logic [NB_W-1:0] NB_LAST = NB_W'(8);

  typedef enum logic [1:0] {
    KIND_INS_POINT = 2'd0,
    KIND_INS_PAIR  = 2'd1,
    KIND_QRY_POINT = 2'd2,
    KIND_QRY_PAIR  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_OUT_OF_DOMAIN = 2'd1,
    ST_BUCKET_FULL   = 2'd2,
    ST_NONE_FOUND    = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DOMAIN_MIN_COLUMN = 3'd0,
    CFG_DOMAIN_MIN_ROW    = 3'd1,
    CFG_DOMAIN_MAX_COLUMN = 3'd2,
    CFG_DOMAIN_MAX_ROW    = 3'd3,
    CFG_CELL_SIZE         = 3'd4,
    CFG_GRID_COLUMNS_USED = 3'd5,
    CFG_GRID_ROWS_USED    = 3'd6
  } cfg_index_e;

  typedef enum logic [1:0] {
    STEP_ZERO  = 2'd0,
    STEP_PLUS  = 2'd1,
    STEP_MINUS = 2'd2
  } step_e;

  // Neighbor scan order: own cell, right column, left column, then above/below.
  localparam step_e SCAN_DC [0:8] = '{STEP_ZERO, STEP_PLUS, STEP_PLUS, STEP_PLUS,
    STEP_MINUS, STEP_MINUS, STEP_MINUS, STEP_ZERO, STEP_ZERO};
  localparam step_e SCAN_DR [0:8] = '{STEP_ZERO, STEP_ZERO, STEP_PLUS, STEP_MINUS,
    STEP_ZERO, STEP_PLUS, STEP_MINUS, STEP_PLUS, STEP_MINUS};

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_DIV, S_CELL, S_NB, S_NB_CHK, S_CNT, S_SCAN,
    S_DRAIN, S_RES
  } state_e;

  typedef struct packed {
    kind_e                 kind;
    logic [COORD_BITS-1:0] point_column;
    logic [COORD_BITS-1:0] point_row;
    logic [IDENT_BITS-1:0] pair_ident;
    logic [COORD_BITS-1:0] pair_column;
    logic [COORD_BITS-1:0] pair_row;
    logic [COORD_BITS-1:0] tolerance;
  } in_item_t;

  typedef struct packed {
    status_e               status;
    logic [COORD_BITS-1:0] found_column;
    logic [COORD_BITS-1:0] found_row;
  } out_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] column;
    logic [COORD_BITS-1:0] row;
    logic                  has_pair;
    logic [IDENT_BITS-1:0] pair_ident;
    logic [COORD_BITS-1:0] pair_column;
    logic [COORD_BITS-1:0] pair_row;
  } entry_t;

  typedef struct packed {
    logic            capture;
    logic            start;
    logic            cell_load;
    logic            nb_load;
    logic [NB_W-1:0] nb_k;
    logic            cnt_rd;
    logic            ins_wr;
    logic            clr_wr;
    logic            scan_start;
    logic            scan_issue;
    logic            out_load;
    status_e         out_status;
    logic            out_point;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_query;
    logic ood;
    logic div_busy;
    logic cell_out;
    logic nb_ok;
    logic bucket_full;
    logic bucket_empty;
    logic scan_last;
    logic pipe_busy;
    logic found;
  } stat_t;

endpackage

@@ rtl/core/gbnp_div.sv @@
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module gbnp_div import gbnp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [COORD_BITS-1:0] dividend_i,
  input  logic [COORD_BITS-1:0] divisor_i,
  output logic                  busy_o,
  output logic [COORD_BITS-1:0] quotient_o
);

  logic [COORD_BITS-1:0] quo_q, quo_d, rem_q, rem_d, dvs_q, dvs_d;
  logic [DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic [COORD_BITS:0]   trial, diff;

  always_comb begin
    trial  = {rem_q, quo_q[COORD_BITS-1]};
    diff   = trial - {1'b0, dvs_q};
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = DIV_CNT_W'(COORD_BITS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff[COORD_BITS-1:0];
        quo_d = {quo_q[COORD_BITS-2:0], 1'b1};
      end else begin
        rem_d = trial[COORD_BITS-1:0];
        quo_d = {quo_q[COORD_BITS-2:0], 1'b0};
      end
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

@@ rtl/core/gbnp_dp.sv @@
// Datapath: config registers, cell mapping, bucket memories, scan pipeline.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gbnp_dp import gbnp_pkg::*; #(
  parameter int GRID_CELLS   = 4096,
  parameter int BUCKET_DEPTH = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  in_item_t             in_item_i,
  output out_item_t            out_item_o,
  input  cmd_t                 cmd_i,
  output stat_t                st_o
);

  localparam int ADDR_W = $clog2(GRID_CELLS);
  localparam int CNT_W  = $clog2(BUCKET_DEPTH + 1);
  localparam int E_W    = $clog2(GRID_CELLS * BUCKET_DEPTH);

  // Configuration
  logic [COORD_BITS-1:0] min_col_q, min_row_q, max_col_q, max_row_q, cell_size_q;
  logic [GDIM_W-1:0]     gcols_q, grows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_col_q   <= '0;
      min_row_q   <= '0;
      max_col_q   <= '1;
      max_row_q   <= '1;
      cell_size_q <= COORD_BITS'(32'd16384);
      gcols_q     <= GDIM_W'(64);
      grows_q     <= GDIM_W'(64);
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_DOMAIN_MIN_COLUMN: min_col_q   <= cfg_data_i[COORD_BITS-1:0];
        CFG_DOMAIN_MIN_ROW:    min_row_q   <= cfg_data_i[COORD_BITS-1:0];
        CFG_DOMAIN_MAX_COLUMN: max_col_q   <= cfg_data_i[COORD_BITS-1:0];
        CFG_DOMAIN_MAX_ROW:    max_row_q   <= cfg_data_i[COORD_BITS-1:0];
        CFG_CELL_SIZE:         cell_size_q <= cfg_data_i[COORD_BITS-1:0];
        CFG_GRID_COLUMNS_USED: gcols_q     <= cfg_data_i[GDIM_W-1:0];
        CFG_GRID_ROWS_USED:    grows_q     <= cfg_data_i[GDIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Item and tolerance
  in_item_t        in_q;
  logic [SQ_W-1:0] tol2_q;
  logic            is_query, pair_query;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= in_item_i;
    end
    if (cmd_i.start) begin
      tol2_q <= SQ_W'(in_q.tolerance) * SQ_W'(in_q.tolerance);
    end
  end

  assign is_query   = (in_q.kind == KIND_QRY_POINT) || (in_q.kind == KIND_QRY_PAIR);
  assign pair_query = (in_q.kind == KIND_QRY_PAIR);

  // Domain check and cell division
  logic                  ood;
  logic [COORD_BITS-1:0] divisor, qcol, qrow;
  logic                  busy_col, busy_row;

  assign ood = (in_q.point_column < min_col_q) || (in_q.point_column > max_col_q) ||
               (in_q.point_row < min_row_q) || (in_q.point_row > max_row_q);
  assign divisor = (cell_size_q == '0) ? COORD_BITS'(1) : cell_size_q;

  gbnp_div u_div_col (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start),
    .dividend_i (in_q.point_column - min_col_q),
    .divisor_i  (divisor),
    .busy_o     (busy_col),
    .quotient_o (qcol)
  );

  gbnp_div u_div_row (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start),
    .dividend_i (in_q.point_row - min_row_q),
    .divisor_i  (divisor),
    .busy_o     (busy_row),
    .quotient_o (qrow)
  );

  logic [XW-1:0]     qcol_x, qrow_x;
  logic              cell_out;
  logic [GDIM_W-1:0] c_q, r_q;

  assign qcol_x   = XW'(qcol);
  assign qrow_x   = XW'(qrow);
  assign cell_out = (qcol_x >= XW'(gcols_q)) || (qrow_x >= XW'(grows_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.cell_load) begin
      c_q <= qcol_x[GDIM_W-1:0];
      r_q <= qrow_x[GDIM_W-1:0];
    end
  end

  // Neighbor cell address
  logic [GDIM_W-1:0] nc, nr;
  logic              nb_skip;
  logic [PROD_W-1:0] prod;
  logic [ADDR_W-1:0] addr_q;
  logic              nb_ok_q;

  always_comb begin
    nb_skip = 1'b0;
    case (SCAN_DC[cmd_i.nb_k])
      STEP_PLUS:  nc = c_q + GDIM_W'(1);
      STEP_MINUS: begin
        nc      = c_q - GDIM_W'(1);
        nb_skip = (c_q == '0);
      end
      default:    nc = c_q;
    endcase
    case (SCAN_DR[cmd_i.nb_k])
      STEP_PLUS:  nr = r_q + GDIM_W'(1);
      STEP_MINUS: begin
        nr      = r_q - GDIM_W'(1);
        nb_skip = nb_skip || (r_q == '0);
      end
      default:    nr = r_q;
    endcase
    prod = PROD_W'(nr) * PROD_W'(gcols_q) + PROD_W'(nc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nb_ok_q <= 1'b0;
    end else if (cmd_i.nb_load) begin
      nb_ok_q <= !nb_skip && (nc < gcols_q) && (nr < grows_q) &&
                 (prod < PROD_W'(GRID_CELLS));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.nb_load) begin
      addr_q <= prod[ADDR_W-1:0];
    end
  end

  // Bucket fill counts, cleared by a sweep after reset
  logic [CNT_W-1:0]  cnt_mem [GRID_CELLS];
  logic [CNT_W-1:0]  cnt_rd_q;
  logic [ADDR_W-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_q <= clr_q + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) begin
      cnt_mem[clr_q] <= '0;
    end else if (cmd_i.ins_wr) begin
      cnt_mem[addr_q] <= cnt_rd_q + CNT_W'(1);
    end
    if (cmd_i.cnt_rd) begin
      cnt_rd_q <= cnt_mem[addr_q];
    end
  end

  // Scan slot counter
  logic [CNT_W-1:0] n_q, i_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) begin
      n_q <= (cnt_rd_q > CNT_W'(BUCKET_DEPTH)) ? CNT_W'(BUCKET_DEPTH) : cnt_rd_q;
      i_q <= '0;
    end else if (cmd_i.scan_issue) begin
      i_q <= i_q + CNT_W'(1);
    end
  end

  // Entry store
  entry_t         ent_mem [GRID_CELLS * BUCKET_DEPTH];
  entry_t         ent_q, ent_wr;
  logic [E_W-1:0] wr_slot, rd_slot;

  assign wr_slot = E_W'(addr_q) * E_W'(BUCKET_DEPTH) + E_W'(cnt_rd_q);
  assign rd_slot = E_W'(addr_q) * E_W'(BUCKET_DEPTH) + E_W'(i_q);

  always_comb begin
    ent_wr.column      = in_q.point_column;
    ent_wr.row         = in_q.point_row;
    ent_wr.has_pair    = (in_q.kind == KIND_INS_PAIR);
    ent_wr.pair_ident  = ent_wr.has_pair ? in_q.pair_ident : '0;
    ent_wr.pair_column = ent_wr.has_pair ? in_q.pair_column : '0;
    ent_wr.pair_row    = ent_wr.has_pair ? in_q.pair_row : '0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_wr) begin
      ent_mem[wr_slot] <= ent_wr;
    end
    if (cmd_i.scan_issue) begin
      ent_q <= ent_mem[rd_slot];
    end
  end

  // Distance pipeline: read, square, compare
  logic                  v1_q, v2_q;
  logic [COORD_BITS-1:0] dx, dy, ex, ey;
  logic [SQ_W-1:0]       sdx_q, sdy_q, sex_q, sey_q;
  logic                  pair_ok_q;
  logic [COORD_BITS-1:0] cand_col_q, cand_row_q;
  logic [DIST_W-1:0]     d2, pd2;
  logic                  qual;
  logic                  found_q;
  logic [DIST_W-1:0]     best_q;
  logic [COORD_BITS-1:0] best_col_q, best_row_q;

  always_comb begin
    dx = (in_q.point_column > ent_q.column) ? in_q.point_column - ent_q.column
                                             : ent_q.column - in_q.point_column;
    dy = (in_q.point_row > ent_q.row) ? in_q.point_row - ent_q.row
                                       : ent_q.row - in_q.point_row;
    ex = (in_q.pair_column > ent_q.pair_column) ? in_q.pair_column - ent_q.pair_column
                                                 : ent_q.pair_column - in_q.pair_column;
    ey = (in_q.pair_row > ent_q.pair_row) ? in_q.pair_row - ent_q.pair_row
                                           : ent_q.pair_row - in_q.pair_row;
    d2   = DIST_W'(sdx_q) + DIST_W'(sdy_q);
    pd2  = DIST_W'(sex_q) + DIST_W'(sey_q);
    qual = (d2 < DIST_W'(tol2_q)) &&
           (!pair_query || (pair_ok_q && (pd2 < DIST_W'(tol2_q))));
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      sdx_q      <= SQ_W'(dx) * SQ_W'(dx);
      sdy_q      <= SQ_W'(dy) * SQ_W'(dy);
      sex_q      <= SQ_W'(ex) * SQ_W'(ex);
      sey_q      <= SQ_W'(ey) * SQ_W'(ey);
      pair_ok_q  <= ent_q.has_pair && (ent_q.pair_ident == in_q.pair_ident);
      cand_col_q <= ent_q.column;
      cand_row_q <= ent_q.row;
    end
    if (v2_q && qual && (!found_q || (d2 < best_q))) begin
      best_q     <= d2;
      best_col_q <= cand_col_q;
      best_row_q <= cand_row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      found_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.scan_issue;
      v2_q <= v1_q;
      if (cmd_i.start) begin
        found_q <= 1'b0;
      end else if (v2_q && qual) begin
        found_q <= 1'b1;
      end
    end
  end

  // Result register
  out_item_t out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.status       <= cmd_i.out_status;
      out_q.found_column <= cmd_i.out_point ? best_col_q : '0;
      out_q.found_row    <= cmd_i.out_point ? best_row_q : '0;
    end
  end

  assign out_item_o = out_q;

  always_comb begin
    st_o.clr_last     = (clr_q == ADDR_W'(GRID_CELLS - 1));
    st_o.is_query     = is_query;
    st_o.ood          = ood;
    st_o.div_busy     = busy_col || busy_row;
    st_o.cell_out     = cell_out;
    st_o.nb_ok        = nb_ok_q;
    st_o.bucket_full  = (cnt_rd_q >= CNT_W'(BUCKET_DEPTH));
    st_o.bucket_empty = (cnt_rd_q == '0);
    st_o.scan_last    = (CNT_W'(i_q + CNT_W'(1)) == n_q);
    st_o.pipe_busy    = v1_q || v2_q;
    st_o.found        = found_q;
  end

  `ASSERT_CLK(a_best_below_tol, found_q |-> (best_q < DIST_W'(tol2_q)), "best above tolerance")
  `ASSERT_CLK(a_found_needs_pipe, $rose(found_q) |-> $past(v2_q), "found set without candidate")
  `ASSERT_NEVER(a_ins_slot_free, cmd_i.ins_wr && (cnt_rd_q >= CNT_W'(BUCKET_DEPTH)), "insert into full bucket")

endmodule

@@ rtl/core/gbnp_ctrl.sv @@
// Controller: sequences insert, query and clearing steps of the datapath.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gbnp_ctrl import gbnp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output cmd_t  cmd_o,
  input  stat_t st_i
);

  state_e          state_q, state_d;
  status_e         status_q, status_d;
  logic [NB_W-1:0] k_q, k_d;
  logic            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      status_q    <= ST_OK;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      status_q    <= status_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    status_d   = status_q;
    k_d        = k_q;
    out_valid_d = out_valid_q && out_stall_i;
    in_stall_o = 1'b1;
    cmd_o      = '0;
    cmd_o.nb_k = k_q;
    cmd_o.out_status = status_q;
    cmd_o.out_point  = st_i.is_query && (status_q == ST_OK);

    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (st_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st_i.ood) begin
          status_d = ST_OUT_OF_DOMAIN;
          state_d  = S_RES;
        end else begin
          cmd_o.start = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (!st_i.div_busy) begin
          state_d = S_CELL;
        end
      end
      S_CELL: begin
        if (st_i.cell_out) begin
          status_d = ST_OUT_OF_DOMAIN;
          state_d  = S_RES;
        end else begin
          cmd_o.cell_load = 1'b1;
          k_d     = '0;
          state_d = S_NB;
        end
      end
      S_NB: begin
        cmd_o.nb_load = 1'b1;
        state_d = S_NB_CHK;
      end
      S_NB_CHK: begin
        if (st_i.nb_ok) begin
          cmd_o.cnt_rd = 1'b1;
          state_d = S_CNT;
        end else if (k_q == '0) begin
          // own cell outside the grid
          status_d = ST_OUT_OF_DOMAIN;
          state_d  = S_RES;
        end else if (k_q == NB_LAST) begin
          state_d = S_DRAIN;
        end else begin
          k_d     = k_q + NB_W'(1);
          state_d = S_NB;
        end
      end
      S_CNT: begin
        if (!st_i.is_query) begin
          if (st_i.bucket_full) begin
            status_d = ST_BUCKET_FULL;
          end else begin
            cmd_o.ins_wr = 1'b1;
            status_d = ST_OK;
          end
          state_d = S_RES;
        end else if (!st_i.bucket_empty) begin
          cmd_o.scan_start = 1'b1;
          state_d = S_SCAN;
        end else if (k_q == NB_LAST) begin
          state_d = S_DRAIN;
        end else begin
          k_d     = k_q + NB_W'(1);
          state_d = S_NB;
        end
      end
      S_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        if (st_i.scan_last) begin
          if (k_q == NB_LAST) begin
            state_d = S_DRAIN;
          end else begin
            k_d     = k_q + NB_W'(1);
            state_d = S_NB;
          end
        end
      end
      S_DRAIN: begin
        if (!st_i.pipe_busy) begin
          status_d = st_i.found ? ST_OK : ST_NONE_FOUND;
          state_d  = S_RES;
        end
      end
      S_RES: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

  `ASSERT_NEVER(a_wr_excl, cmd_o.ins_wr && cmd_o.clr_wr, "insert during clear")
  `ASSERT_CLK(a_res_drained, (state_q == S_RES) |-> !st_i.pipe_busy, "result before drain")
  `ASSERT_CLK(a_div_done, (state_q == S_CELL) |-> !st_i.div_busy, "cell check before divide")

endmodule

@@ rtl/core/grid_bucket_nearest_point.sv @@
// Top level of the grid bucket nearest point store.
// Usage:
//  - Input channel (in_valid_i/in_stall_o/in_item_i) takes one item: insert
//    point, insert pair, query point or query pair. Output channel
//    (out_valid_o/out_stall_i/out_item_o) returns exactly one item per input.
//  - Config: write cfg_data_i to register cfg_index_i while cfg_we_i is high;
//    only while no item is in flight.
//  - One item at a time. Steps per item: domain check, two bit-serial
//    cell dividers, cell mapping, then per visited cell the address
//    multiply, fill count read and decision. An insert ends after the
//    first cell. A query also reads each stored entry (up to
//    9*BUCKET_DEPTH) and then drains the distance pipeline.
//  - Throughput is set by the divider loop and the single entry read port.
//  - After reset the bucket counts are swept to zero, one cell per cycle,
//    over all GRID_CELLS cells; in_stall_o stays high during the sweep.
//  - The result waits in an output register; the next item is taken while
//    it is stalled, and that item's result holds until the register frees.
`timescale 1ns / 1ps
module grid_bucket_nearest_point import gbnp_pkg::*; #(
  parameter int GRID_CELLS   = 4096,
  parameter int BUCKET_DEPTH = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o
);

  cmd_t  cmd;
  stat_t st;

  gbnp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .st_i        (st)
  );

  gbnp_dp #(
    .GRID_CELLS   (GRID_CELLS),
    .BUCKET_DEPTH (BUCKET_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .st_o        (st)
  );

endmodule
